[rtl/core/ope_pkg.sv]
// ope_pkg: shared types, constants and the microcode table of the
// orthogonal polynomial evaluator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ope_pkg;

    localparam int unsigned MAX_DEGREE_DEF = 32;
    localparam int unsigned X_FRAC_DEF     = 28;
    localparam int unsigned OUT_FRAC_DEF   = 32;

    localparam int unsigned X_W        = 32;
    localparam int unsigned DEG_W      = 6;
    localparam int unsigned RES_W      = 64;
    localparam int unsigned FAM_W      = 3;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned UPC_W      = 6;

    localparam logic [FAM_W-1:0] FAM_LEGENDRE = 3'd0;
    localparam logic [FAM_W-1:0] FAM_CHEB1    = 3'd1;
    localparam logic [FAM_W-1:0] FAM_CHEB2    = 3'd2;
    localparam logic [FAM_W-1:0] FAM_LAGUERRE = 3'd3;
    localparam logic [FAM_W-1:0] FAM_HERMITE  = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_FMUL, OP_IMUL, OP_IDIV, OP_FDIV, OP_XSQ, OP_XQ
    } op_t;

    typedef enum logic [3:0] {
        SEL_ZERO, SEL_ONE, SEL_XR, SEL_XQ, SEL_YL, SEL_YLM1, SEL_DYL, SEL_DYLM1,
        SEL_T1, SEL_T2, SEL_T3, SEL_W
    } sel_t;

    typedef enum logic [3:0] {
        K_NONE, K_K, K_2K1, K_2K, K_2K2, K_KP1, K_TWO, K_L, K_TRI, K_SHIFT
    } ksel_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_XQ, ST_Y1, ST_LOOP, ST_BODY, ST_STEP, ST_TAIL, ST_FIN, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        AL_IDLE, AL_MUL, AL_DIV, AL_POST
    } alu_state_t;

    typedef struct packed {
        op_t   op;
        sel_t  a;
        sel_t  b;
        ksel_t k;
        sel_t  dst;
        logic  last;
    } uinstr_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] kval;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [63:0] value;
    } alu_rsp_t;

    // microcode entry points
    localparam logic [UPC_W-1:0] UPC_XQ     = 6'd0;
    localparam logic [UPC_W-1:0] UPC_Y1_LIN = 6'd1;
    localparam logic [UPC_W-1:0] UPC_Y1_LAG = 6'd2;
    localparam logic [UPC_W-1:0] UPC_Y1_DBL = 6'd3;
    localparam logic [UPC_W-1:0] UPC_LEG    = 6'd4;
    localparam logic [UPC_W-1:0] UPC_CHEB   = 6'd9;
    localparam logic [UPC_W-1:0] UPC_LAG    = 6'd16;
    localparam logic [UPC_W-1:0] UPC_HER    = 6'd27;
    localparam logic [UPC_W-1:0] UPC_LDER   = 6'd32;
    localparam logic [UPC_W-1:0] UPC_LEND   = 6'd37;

    function automatic uinstr_t ucode(input logic [UPC_W-1:0] pc);
        uinstr_t r;
        case (pc)
            // point to output format
            6'd0:  r = '{OP_XQ,   SEL_XR,    SEL_ZERO,  K_SHIFT, SEL_XQ, 1'b1};
            // first-degree term
            6'd1:  r = '{OP_ADD,  SEL_XQ,    SEL_ZERO,  K_NONE,  SEL_T1, 1'b1};
            6'd2:  r = '{OP_SUB,  SEL_ONE,   SEL_XQ,    K_NONE,  SEL_T1, 1'b1};
            6'd3:  r = '{OP_IMUL, SEL_XQ,    SEL_ZERO,  K_TWO,   SEL_T1, 1'b1};
            // legendre step
            6'd4:  r = '{OP_FMUL, SEL_XQ,    SEL_YL,    K_NONE,  SEL_T1, 1'b0};
            6'd5:  r = '{OP_IMUL, SEL_T1,    SEL_ZERO,  K_2K1,   SEL_T1, 1'b0};
            6'd6:  r = '{OP_IMUL, SEL_YLM1,  SEL_ZERO,  K_K,     SEL_T2, 1'b0};
            6'd7:  r = '{OP_SUB,  SEL_T1,    SEL_T2,    K_NONE,  SEL_T1, 1'b0};
            6'd8:  r = '{OP_IDIV, SEL_T1,    SEL_ZERO,  K_KP1,   SEL_T1, 1'b1};
            // chebyshev step
            6'd9:  r = '{OP_FMUL, SEL_XQ,    SEL_YL,    K_NONE,  SEL_T1, 1'b0};
            6'd10: r = '{OP_IMUL, SEL_T1,    SEL_ZERO,  K_TWO,   SEL_T1, 1'b0};
            6'd11: r = '{OP_SUB,  SEL_T1,    SEL_YLM1,  K_NONE,  SEL_T1, 1'b0};
            6'd12: r = '{OP_FMUL, SEL_XQ,    SEL_DYL,   K_NONE,  SEL_T2, 1'b0};
            6'd13: r = '{OP_ADD,  SEL_YL,    SEL_T2,    K_NONE,  SEL_T2, 1'b0};
            6'd14: r = '{OP_IMUL, SEL_T2,    SEL_ZERO,  K_TWO,   SEL_T2, 1'b0};
            6'd15: r = '{OP_SUB,  SEL_T2,    SEL_DYLM1, K_NONE,  SEL_T2, 1'b1};
            // laguerre step
            6'd16: r = '{OP_IMUL, SEL_ONE,   SEL_ZERO,  K_2K1,   SEL_W,  1'b0};
            6'd17: r = '{OP_SUB,  SEL_W,     SEL_XQ,    K_NONE,  SEL_W,  1'b0};
            6'd18: r = '{OP_FMUL, SEL_W,     SEL_YL,    K_NONE,  SEL_T1, 1'b0};
            6'd19: r = '{OP_IMUL, SEL_YLM1,  SEL_ZERO,  K_K,     SEL_T2, 1'b0};
            6'd20: r = '{OP_SUB,  SEL_T1,    SEL_T2,    K_NONE,  SEL_T1, 1'b0};
            6'd21: r = '{OP_IDIV, SEL_T1,    SEL_ZERO,  K_KP1,   SEL_T1, 1'b0};
            6'd22: r = '{OP_FMUL, SEL_W,     SEL_DYL,   K_NONE,  SEL_T2, 1'b0};
            6'd23: r = '{OP_SUB,  SEL_T2,    SEL_YL,    K_NONE,  SEL_T2, 1'b0};
            6'd24: r = '{OP_IMUL, SEL_DYLM1, SEL_ZERO,  K_K,     SEL_T3, 1'b0};
            6'd25: r = '{OP_SUB,  SEL_T2,    SEL_T3,    K_NONE,  SEL_T2, 1'b0};
            6'd26: r = '{OP_IDIV, SEL_T2,    SEL_ZERO,  K_KP1,   SEL_T2, 1'b1};
            // hermite step
            6'd27: r = '{OP_FMUL, SEL_XQ,    SEL_YL,    K_NONE,  SEL_T1, 1'b0};
            6'd28: r = '{OP_IMUL, SEL_T1,    SEL_ZERO,  K_TWO,   SEL_T1, 1'b0};
            6'd29: r = '{OP_IMUL, SEL_YLM1,  SEL_ZERO,  K_2K,    SEL_T2, 1'b0};
            6'd30: r = '{OP_SUB,  SEL_T1,    SEL_T2,    K_NONE,  SEL_T1, 1'b0};
            6'd31: r = '{OP_IMUL, SEL_YL,    SEL_ZERO,  K_2K2,   SEL_T2, 1'b1};
            // legendre slope, interior point
            6'd32: r = '{OP_FMUL, SEL_XQ,    SEL_YL,    K_NONE,  SEL_T1, 1'b0};
            6'd33: r = '{OP_SUB,  SEL_T1,    SEL_YLM1,  K_NONE,  SEL_T1, 1'b0};
            6'd34: r = '{OP_XSQ,  SEL_XR,    SEL_ZERO,  K_NONE,  SEL_T2, 1'b0};
            6'd35: r = '{OP_FDIV, SEL_T1,    SEL_T2,    K_NONE,  SEL_T1, 1'b0};
            6'd36: r = '{OP_IMUL, SEL_T1,    SEL_ZERO,  K_L,     SEL_T3, 1'b1};
            // legendre slope, endpoint
            6'd37: r = '{OP_IMUL, SEL_ONE,   SEL_ZERO,  K_TRI,   SEL_T3, 1'b1};
            default: r = '{OP_ADD, SEL_ZERO, SEL_ZERO,  K_NONE,  SEL_T3, 1'b1};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ope_stream_if.sv]
// ope_in_if / ope_out_if: valid-ready request and result channels of the evaluator.
// Depends on ope_pkg for payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface ope_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ope_pkg::X_W-1:0]      x_value;
    logic        [ope_pkg::DEG_W-1:0]    degree;

    modport source (output valid, output x_value, output degree, input ready);
    modport sink   (input valid, input x_value, input degree, output ready);
endinterface

interface ope_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ope_pkg::RES_W-1:0]    poly_value;
    logic signed [ope_pkg::RES_W-1:0]    poly_derivative;
    logic                                domain_error;
    logic                                overflow;

    modport source (output valid, output poly_value, output poly_derivative,
                    output domain_error, output overflow, input ready);
    modport sink   (input valid, input poly_value, input poly_derivative,
                    input domain_error, input overflow, output ready);
endinterface

`default_nettype wire

[rtl/core/orthogonal_polynomial_eval.sv]
// step cost: each recurrence step is shortest for hermite and longest for laguerre, and the
// legendre slope away from the endpoints adds a further microcode pass; set by the
// shared arithmetic unit (add or subtract, multiply, integer divide, fixed-point
// divide, one operation at a time) under a microcode sequencer
// throughput: one request at a time, next request taken after the result is taken
// reset: asynchronous active-low, clears control state and family register to legendre
`timescale 1ns / 1ps
`default_nettype none

// orthogonal_polynomial_eval: top level, microcode sequencer, term registers,
// config port. Depends on ope_pkg, ope_stream_if and ope_alu.
module orthogonal_polynomial_eval #(
    parameter int unsigned MAX_DEGREE    = ope_pkg::MAX_DEGREE_DEF,
    parameter int unsigned X_FRAC_BITS   = ope_pkg::X_FRAC_DEF,
    parameter int unsigned OUT_FRAC_BITS = ope_pkg::OUT_FRAC_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    ope_in_if.sink                               in_ch,
    ope_out_if.source                            out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ope_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);
    import ope_pkg::*;

    // fixed-point constants
    localparam logic [63:0]        ONE_Q    = 64'd1 << OUT_FRAC_BITS;
    localparam logic signed [31:0] XONE     = 32'sd1 <<< X_FRAC_BITS;
    localparam logic signed [31:0] XMONE    = -XONE;
    localparam int unsigned        SHIFT_XQ = (OUT_FRAC_BITS >= X_FRAC_BITS) ?
                                              (OUT_FRAC_BITS - X_FRAC_BITS) :
                                              (X_FRAC_BITS - OUT_FRAC_BITS);
    localparam logic [63:0]        KSHIFT   = 64'd1 << SHIFT_XQ;
    // scaling the point up is an exact multiply, scaling down a rounded divide
    localparam op_t                XQ_OP    = (OUT_FRAC_BITS >= X_FRAC_BITS) ?
                                              OP_IMUL : OP_IDIV;
    localparam logic [DEG_W-1:0]   DEG_CAP  = DEG_W'(MAX_DEGREE);

    state_t            state_reg, state_next;
    logic [FAM_W-1:0]  fam_reg, fam_next;
    logic [31:0]       point_reg, point_next;
    logic [DEG_W-1:0]  l_reg, l_next;
    logic [DEG_W-1:0]  k_reg, k_next;
    logic [UPC_W-1:0]  pc_reg, pc_next;
    logic              issued_reg, issued_next;
    logic              sat_reg, sat_next;
    logic              dom_reg, dom_next;

    // term and slope registers, scratch
    logic [63:0] xq_reg, xq_next;
    logic [63:0] yl_reg, yl_next;
    logic [63:0] ylm1_reg, ylm1_next;
    logic [63:0] dyl_reg, dyl_next;
    logic [63:0] dylm1_reg, dylm1_next;
    logic [63:0] t1_reg, t1_next;
    logic [63:0] t2_reg, t2_next;
    logic [63:0] t3_reg, t3_next;
    logic [63:0] w_reg, w_next;
    logic [63:0] deriv_reg, deriv_next;

    uinstr_t     cur;
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;
    logic        alu_start;
    logic        exec_st;
    logic [63:0] a_val;
    logic [63:0] b_val;
    logic [63:0] kval;
    logic [63:0] xr64;
    logic        in_acc;
    logic        cfg_wr;
    logic        at_end;

    assign cur     = ucode(pc_reg);
    assign xr64    = {{32{point_reg[31]}}, point_reg};
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign exec_st = state_reg inside {ST_XQ, ST_Y1, ST_BODY, ST_TAIL};
    assign alu_start = exec_st && !issued_reg;
    assign at_end  = ($signed(point_reg) == XONE) || ($signed(point_reg) == XMONE);

    // config port: one register, the family code
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[CFG_ADDR_W-1];
    assign prdata = paddr[CFG_ADDR_W-1] ? 32'd0 : {{(32 - FAM_W){1'b0}}, fam_reg};
    assign fam_next = cfg_wr ? pwdata[FAM_W-1:0] : fam_reg;

    // operand selection for the current microinstruction
    function automatic logic [63:0] pick(input sel_t s, input logic [63:0] xr,
                                         input logic [63:0] xq, input logic [63:0] yl,
                                         input logic [63:0] ylm1, input logic [63:0] dyl,
                                         input logic [63:0] dylm1, input logic [63:0] t1,
                                         input logic [63:0] t2, input logic [63:0] t3,
                                         input logic [63:0] w);
        logic [63:0] v;
        case (s)
            SEL_ONE:   v = ONE_Q;
            SEL_XR:    v = xr;
            SEL_XQ:    v = xq;
            SEL_YL:    v = yl;
            SEL_YLM1:  v = ylm1;
            SEL_DYL:   v = dyl;
            SEL_DYLM1: v = dylm1;
            SEL_T1:    v = t1;
            SEL_T2:    v = t2;
            SEL_T3:    v = t3;
            SEL_W:     v = w;
            default:   v = 64'd0;
        endcase
        return v;
    endfunction

    assign a_val = pick(cur.a, xr64, xq_reg, yl_reg, ylm1_reg, dyl_reg, dylm1_reg,
                        t1_reg, t2_reg, t3_reg, w_reg);
    assign b_val = pick(cur.b, xr64, xq_reg, yl_reg, ylm1_reg, dyl_reg, dylm1_reg,
                        t1_reg, t2_reg, t3_reg, w_reg);

    // integer factors of the recurrence
    always_comb
    begin
        logic [DEG_W:0]     lp1;
        logic [2*DEG_W+1:0] tri_val;
        lp1 = {1'b0, l_reg} + 1'b1;
        tri_val = ({(DEG_W + 1)'(l_reg), {(DEG_W + 1){1'b0}}} >> (DEG_W + 1)) * lp1;
        case (cur.k)
            K_K:     kval = 64'(k_reg);
            K_2K1:   kval = 64'({k_reg, 1'b1});
            K_2K:    kval = 64'({k_reg, 1'b0});
            K_2K2:   kval = 64'({k_reg, 1'b0}) + 64'd2;
            K_KP1:   kval = 64'(k_reg) + 64'd1;
            K_TWO:   kval = 64'd2;
            K_L:     kval = 64'(l_reg);
            K_TRI:   kval = 64'(tri_val >> 1);
            K_SHIFT: kval = KSHIFT;
            default: kval = 64'd0;
        endcase
    end

    assign alu_req = '{(cur.op == OP_XQ) ? XQ_OP : cur.op, a_val, b_val, kval};

    ope_alu #(
        .X_FRAC_BITS   (X_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (alu_start),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = (fam_reg > FAM_HERMITE) ? ST_DONE : ST_XQ;
            end
            ST_XQ: if (alu_rsp.done) state_next = ST_Y1;
            ST_Y1: if (alu_rsp.done) state_next = ST_LOOP;
            ST_LOOP:
            begin
                if (k_reg < l_reg) begin
                    if (k_reg != '0) state_next = ST_BODY;
                end
                else if ((fam_reg == FAM_LEGENDRE) && (l_reg > DEG_W'(1))) begin
                    state_next = ST_TAIL;
                end
                else begin
                    state_next = ST_DONE;
                end
            end
            ST_BODY: if (alu_rsp.done && cur.last) state_next = ST_STEP;
            ST_STEP: state_next = ST_LOOP;
            ST_TAIL: if (alu_rsp.done && cur.last) state_next = ST_FIN;
            ST_FIN:  state_next = ST_DONE;
            ST_DONE: if (out_ch.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer datapath updates
    always_comb
    begin
        logic [DEG_W-1:0] deg;
        logic signed [31:0] xin;

        point_next  = point_reg;
        l_next      = l_reg;
        k_next      = k_reg;
        pc_next     = pc_reg;
        issued_next = issued_reg;
        sat_next    = sat_reg;
        dom_next    = dom_reg;
        xq_next     = xq_reg;
        yl_next     = yl_reg;
        ylm1_next   = ylm1_reg;
        dyl_next    = dyl_reg;
        dylm1_next  = dylm1_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        t3_next     = t3_reg;
        w_next      = w_reg;
        deriv_next  = deriv_reg;

        deg = in_ch.degree;
        xin = in_ch.x_value;

        if (alu_start)
            issued_next = 1'b1;

        // write back a finished operation
        if (alu_rsp.done) begin
            issued_next = 1'b0;
            sat_next    = sat_reg | alu_rsp.sat;
            if (!cur.last)
                pc_next = pc_reg + 1'b1;
            case (cur.dst)
                SEL_XQ:  xq_next = alu_rsp.value;
                SEL_T1:  t1_next = alu_rsp.value;
                SEL_T2:  t2_next = alu_rsp.value;
                SEL_T3:  t3_next = alu_rsp.value;
                SEL_W:   w_next  = alu_rsp.value;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc) begin
                    point_next = xin;
                    l_next     = (deg > DEG_CAP) ? DEG_CAP : deg;
                    k_next     = '0;
                    sat_next   = 1'b0;
                    pc_next    = UPC_XQ;
                    ylm1_next  = '0;
                    dyl_next   = '0;
                    dylm1_next = '0;
                    deriv_next = '0;
                    if (fam_reg > FAM_HERMITE) begin
                        // unused family code
                        yl_next  = '0;
                        dom_next = 1'b1;
                    end
                    else begin
                        yl_next = ONE_Q;
                        if (fam_reg == FAM_LAGUERRE)
                            dom_next = xin < 0;
                        else if (fam_reg == FAM_HERMITE)
                            dom_next = 1'b0;
                        else
                            dom_next = (xin > XONE) || (xin < XMONE);
                    end
                end
            end
            ST_XQ:
            begin
                if (alu_rsp.done) begin
                    case (fam_reg)
                        FAM_LEGENDRE, FAM_CHEB1: pc_next = UPC_Y1_LIN;
                        FAM_LAGUERRE:            pc_next = UPC_Y1_LAG;
                        default:                 pc_next = UPC_Y1_DBL;
                    endcase
                end
            end
            ST_LOOP:
            begin
                if (k_reg < l_reg) begin
                    if (k_reg == '0) begin
                        // first step takes the degree-one term directly
                        ylm1_next  = yl_reg;
                        yl_next    = t1_reg;
                        dylm1_next = dyl_reg;
                        case (fam_reg)
                            FAM_LEGENDRE: dyl_next = '0;
                            FAM_CHEB1:    dyl_next = ONE_Q;
                            FAM_LAGUERRE: dyl_next = 64'd0 - ONE_Q;
                            default:      dyl_next = ONE_Q << 1;
                        endcase
                        k_next = k_reg + 1'b1;
                    end
                    else begin
                        case (fam_reg)
                            FAM_LEGENDRE: pc_next = UPC_LEG;
                            FAM_LAGUERRE: pc_next = UPC_LAG;
                            FAM_HERMITE:  pc_next = UPC_HER;
                            default:      pc_next = UPC_CHEB;
                        endcase
                    end
                end
                else if (fam_reg == FAM_LEGENDRE) begin
                    if (l_reg == '0)
                        deriv_next = '0;
                    else if (l_reg == DEG_W'(1))
                        deriv_next = ONE_Q;
                    else
                        pc_next = at_end ? UPC_LEND : UPC_LDER;
                end
                else begin
                    deriv_next = dyl_reg;
                end
            end
            ST_STEP:
            begin
                ylm1_next  = yl_reg;
                yl_next    = t1_reg;
                dylm1_next = dyl_reg;
                dyl_next   = (fam_reg == FAM_LEGENDRE) ? 64'd0 : t2_reg;
                k_next     = k_reg + 1'b1;
            end
            ST_FIN:
            begin
                // sign flips at x = -1 for even degree
                if (($signed(point_reg) == XMONE) && !l_reg[0])
                    deriv_next = 64'd0 - t3_reg;
                else
                    deriv_next = t3_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            fam_reg    <= FAM_LEGENDRE;
            issued_reg <= 1'b0;
            point_reg  <= '0;
            l_reg      <= '0;
            k_reg      <= '0;
            pc_reg     <= UPC_XQ;
            sat_reg    <= 1'b0;
            dom_reg    <= 1'b0;
            yl_reg     <= '0;
            ylm1_reg   <= '0;
            dyl_reg    <= '0;
            dylm1_reg  <= '0;
            deriv_reg  <= '0;
        end
        else begin
            state_reg  <= state_next;
            fam_reg    <= fam_next;
            issued_reg <= issued_next;
            point_reg  <= point_next;
            l_reg      <= l_next;
            k_reg      <= k_next;
            pc_reg     <= pc_next;
            sat_reg    <= sat_next;
            dom_reg    <= dom_next;
            yl_reg     <= yl_next;
            ylm1_reg   <= ylm1_next;
            dyl_reg    <= dyl_next;
            dylm1_reg  <= dylm1_next;
            deriv_reg  <= deriv_next;
        end
    end

    // scratch registers carry no reset
    always_ff @(posedge clk)
    begin
        xq_reg <= xq_next;
        t1_reg <= t1_next;
        t2_reg <= t2_next;
        t3_reg <= t3_next;
        w_reg  <= w_next;
    end

    // handshake outputs
    assign in_ch.ready            = (state_reg == ST_IDLE);
    assign out_ch.valid           = (state_reg == ST_DONE);
    assign out_ch.poly_value      = yl_reg;
    assign out_ch.poly_derivative = deriv_reg;
    assign out_ch.domain_error    = dom_reg;
    assign out_ch.overflow        = sat_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("result pending while a new request is taken");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= l_reg)
        else $error("recurrence step past clamped degree");

    a_rsp_issued: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> issued_reg)
        else $error("arithmetic result without an issued operation");

    a_degree_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (l_reg <= DEG_CAP))
        else $error("degree not clamped");
`endif

endmodule

`default_nettype wire

[rtl/core/ope_alu.sv]
// ope_alu: shared saturating arithmetic unit (add, sub, fixed-point and
// integer multiply, point squared less one, rounded divide). Depends on ope_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ope_alu #(
    parameter int unsigned X_FRAC_BITS   = ope_pkg::X_FRAC_DEF,
    parameter int unsigned OUT_FRAC_BITS = ope_pkg::OUT_FRAC_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire ope_pkg::alu_req_t req,
    output ope_pkg::alu_rsp_t      rsp
);
    import ope_pkg::*;

    localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] SMIN = {1'b1, 63'b0};

    alu_state_t   st_reg, st_next;
    op_t          op_reg, op_next;
    logic         neg_reg, neg_next;
    logic [1:0]   mcnt_reg, mcnt_next;
    logic [7:0]   dcnt_reg, dcnt_next;
    logic [63:0]  ma_reg, ma_next;
    logic [63:0]  mb_reg, mb_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  res_reg, res_next;
    logic         sat_reg, sat_next;
    logic         done_reg, done_next;

    function automatic logic [63:0] magn(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // saturating sign/magnitude to two's complement, {sat, value}
    function automatic logic [64:0] pack(input logic neg, input logic [63:0] m,
                                         input logic big);
        logic [64:0] r;
        if (neg) begin
            if (big || (m > SMIN)) r = {1'b1, SMIN};
            else                   r = {1'b0, 64'd0 - m};
        end
        else begin
            if (big || m[63]) r = {1'b1, SMAX};
            else              r = {1'b0, m};
        end
        return r;
    endfunction

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            AL_IDLE:
            begin
                if (start) begin
                    case (req.op)
                        OP_FMUL, OP_IMUL, OP_XSQ: st_next = AL_MUL;
                        OP_IDIV, OP_FDIV:         st_next = AL_DIV;
                        default:                  st_next = AL_IDLE;
                    endcase
                end
            end
            AL_MUL:  if (mcnt_reg == 2'd3) st_next = AL_POST;
            AL_DIV:  if (dcnt_reg == 8'd1) st_next = AL_POST;
            AL_POST: st_next = AL_IDLE;
            default: st_next = AL_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        logic [63:0]  s;
        logic [31:0]  pa;
        logic [31:0]  pb;
        logic [63:0]  prod;
        logic [6:0]   shamt;
        logic [64:0]  rsh;
        logic         ge;
        logic [127:0] sum;
        logic         rnd;
        logic [64:0]  pk;

        op_next   = op_reg;
        neg_next  = neg_reg;
        mcnt_next = mcnt_reg;
        dcnt_next = dcnt_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        sat_next  = sat_reg;
        done_next = 1'b0;

        s     = '0;
        pa    = mcnt_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        pb    = mcnt_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        prod  = 64'(pa) * 64'(pb);
        shamt = {mcnt_reg[0] & mcnt_reg[1], mcnt_reg[0] ^ mcnt_reg[1], 5'b0};
        rsh   = {rem_reg, acc_reg[127]};
        ge    = rsh >= {1'b0, mb_reg};
        sum   = '0;
        rnd   = 1'b0;
        pk    = '0;

        case (st_reg)
            AL_IDLE:
            begin
                if (start) begin
                    op_next   = req.op;
                    mcnt_next = 2'd0;
                    acc_next  = '0;
                    rem_next  = '0;
                    case (req.op)
                        OP_ADD:
                        begin
                            s = req.a + req.b;
                            done_next = 1'b1;
                            if ((req.a[63] == req.b[63]) && (s[63] != req.a[63])) begin
                                res_next = req.a[63] ? SMIN : SMAX;
                                sat_next = 1'b1;
                            end
                            else begin
                                res_next = s;
                                sat_next = 1'b0;
                            end
                        end
                        OP_SUB:
                        begin
                            s = req.a - req.b;
                            done_next = 1'b1;
                            if ((req.a[63] != req.b[63]) && (s[63] != req.a[63])) begin
                                res_next = req.a[63] ? SMIN : SMAX;
                                sat_next = 1'b1;
                            end
                            else begin
                                res_next = s;
                                sat_next = 1'b0;
                            end
                        end
                        OP_FMUL:
                        begin
                            ma_next  = magn(req.a);
                            mb_next  = magn(req.b);
                            neg_next = req.a[63] ^ req.b[63];
                        end
                        OP_IMUL:
                        begin
                            ma_next  = magn(req.a);
                            mb_next  = req.kval;
                            neg_next = req.a[63];
                        end
                        OP_XSQ:
                        begin
                            ma_next  = magn(req.a);
                            mb_next  = magn(req.a);
                            neg_next = 1'b0;
                        end
                        OP_IDIV:
                        begin
                            acc_next  = {magn(req.a), 64'd0};
                            mb_next   = req.kval;
                            neg_next  = req.a[63];
                            dcnt_next = 8'd64;
                        end
                        OP_FDIV:
                        begin
                            acc_next  = 128'(magn(req.a)) << (2 * X_FRAC_BITS);
                            mb_next   = magn(req.b);
                            neg_next  = req.a[63] ^ req.b[63];
                            dcnt_next = 8'd128;
                        end
                        default:
                        begin
                            res_next  = '0;
                            sat_next  = 1'b0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            AL_MUL:
            begin
                // one 32x32 partial product per cycle
                acc_next  = acc_reg + (128'(prod) << shamt);
                mcnt_next = mcnt_reg + 2'd1;
            end
            AL_DIV:
            begin
                // restoring divide, quotient shifts in behind the dividend
                rem_next  = ge ? 64'(rsh - {1'b0, mb_reg}) : rsh[63:0];
                acc_next  = {acc_reg[126:0], ge};
                dcnt_next = dcnt_reg - 8'd1;
            end
            AL_POST:
            begin
                done_next = 1'b1;
                case (op_reg)
                    OP_FMUL:
                    begin
                        sum = acc_reg + (128'd1 << (OUT_FRAC_BITS - 1));
                        pk  = pack(neg_reg, sum[OUT_FRAC_BITS +: 64],
                                   |(sum >> (OUT_FRAC_BITS + 64)));
                    end
                    OP_IMUL:
                        pk = pack(neg_reg && (|acc_reg[63:0]), acc_reg[63:0],
                                  |acc_reg[127:64]);
                    OP_XSQ:
                        pk = {1'b0, acc_reg[63:0] - (64'd1 << (2 * X_FRAC_BITS))};
                    OP_IDIV, OP_FDIV:
                    begin
                        rnd = {rem_reg, 1'b0} >= {1'b0, mb_reg};
                        sum = acc_reg + 128'(rnd);
                        pk  = pack(neg_reg && (|sum), sum[63:0], |sum[127:64]);
                    end
                    default: pk = '0;
                endcase
                sat_next = pk[64];
                res_next = pk[63:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg   <= AL_IDLE;
            done_reg <= 1'b0;
        end
        else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        neg_reg  <= neg_next;
        mcnt_reg <= mcnt_next;
        dcnt_reg <= dcnt_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        sat_reg  <= sat_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.sat   = sat_reg;
    assign rsp.value = res_reg;

endmodule

`default_nettype wire

[verif/ope_tb_if.sv]
// ope_tb_if: holds the ope_tb_types package; the channel interfaces come from rtl/core/ope_stream_if.sv
// depends on no other file
`timescale 1ns / 1ps

package ope_tb_types;
    typedef struct packed {
        logic signed [63:0] value;
        logic signed [63:0] slope;
        logic               dom;
        logic               ovf;
    } ope_result_t;
endpackage

[verif/tb.sv]
// tb: self-checking bench for orthogonal_polynomial_eval, predicts each
// request with a bit-true recurrence model. Depends on ope_pkg, ope_tb_types, ope_stream_if.
`timescale 1ns / 1ps

module tb;
    import ope_pkg::*;
    import ope_tb_types::*;

    localparam int XF = 28;
    localparam int OF = 32;
    localparam longint LIMIT = 64'd60_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    ope_in_if  in_ch();
    ope_out_if out_ch();

    orthogonal_polynomial_eval uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    typedef struct packed {
        logic [31:0] x;
        logic [5:0]  deg;
    } eval_req_t;

    eval_req_t   pending_reqs[$];
    ope_result_t expected_results[$];
    logic [2:0]  fam_cfg;
    bit          sat_flag;
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_recv = 1'b0;
    bit          in_fire = 1'b0;
    longint      cycles = 0;

    // ---------------- fixed point arithmetic, saturating ----------------
    function automatic logic signed [63:0] sat_pack(bit neg, logic [127:0] m);
        if (neg) begin
            if (m > 128'h8000_0000_0000_0000) begin
                sat_flag = 1;
                return 64'sh8000_0000_0000_0000;
            end
            return -$signed(m[63:0]);
        end
        if (m > 128'h7FFF_FFFF_FFFF_FFFF) begin
            sat_flag = 1;
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return $signed(m[63:0]);
    endfunction

    function automatic logic [63:0] mag(logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic signed [63:0] s_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = a + b;
        return sat_pack(s[64], s[64] ? -s : s);
    endfunction

    function automatic logic signed [63:0] s_sub(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = a - b;
        return sat_pack(s[64], s[64] ? -s : s);
    endfunction

    // sign only kept when the low word is nonzero
    function automatic logic signed [63:0] i_mul(logic signed [63:0] a, logic [63:0] k);
        logic [127:0] p;
        p = mag(a) * k;
        return sat_pack(a[63] && p[63:0] != 0, p);
    endfunction

    function automatic logic signed [63:0] i_div(logic signed [63:0] a, logic [63:0] k);
        logic [63:0] m, q, r;
        m = mag(a); q = m / k; r = m % k;
        if (r >= k - r) q++;
        return sat_pack(a[63], {64'd0, q});
    endfunction

    function automatic logic signed [63:0] f_mul(logic signed [63:0] a, logic signed [63:0] b);
        logic [127:0] p;
        p = mag(a) * mag(b) + (128'd1 << (OF - 1));
        p = p >> OF;
        return sat_pack(a[63] != b[63], p);
    endfunction

    // quotient of output-format n by d carrying 2*XF fraction bits
    function automatic logic signed [63:0] f_div(logic signed [63:0] n, logic signed [63:0] d);
        logic [127:0] num, q, r;
        num = {64'd0, mag(n)} << (2 * XF);
        q = num / mag(d); r = num % mag(d);
        if (r >= mag(d) - r) q++;
        return sat_pack(n[63] != d[63] && q != 0, q);
    endfunction

    // ---------------- recurrence predictor ----------------
    function automatic ope_result_t eval_poly(logic [31:0] xin, logic [5:0] dg);
        ope_result_t res;
        logic signed [63:0] xr, one, xone, xq, y1, dy1, yl, ylm1, dyl, dylm1, nv, nd, dv, w, d;
        logic [63:0] mx;
        int l;
        bit dom;
        xr = $signed(xin); one = 64'sd1 <<< OF; xone = 64'sd1 <<< XF;
        l = (dg > 32) ? 32 : dg;
        sat_flag = 0;
        if (fam_cfg > FAM_HERMITE) begin
            res = '{64'sd0, 64'sd0, 1'b1, 1'b0};
            return res;
        end
        xq = i_mul(xr, 64'd1 << (OF - XF));
        if (fam_cfg <= FAM_CHEB2) dom = xr > xone || xr < -xone;
        else if (fam_cfg == FAM_LAGUERRE) dom = xr < 0;
        else dom = 0;
        if (fam_cfg == FAM_LEGENDRE || fam_cfg == FAM_CHEB1) begin y1 = xq; dy1 = one; end
        else if (fam_cfg == FAM_LAGUERRE) begin y1 = s_sub(one, xq); dy1 = -one; end
        else begin y1 = i_mul(xq, 2); dy1 = i_mul(one, 2); end
        yl = one; ylm1 = 0; dyl = 0; dylm1 = 0;
        for (int k = 0; k < l; k++) begin
            if (k == 0) begin
                ylm1 = yl; yl = y1; dylm1 = dyl;
                dyl = (fam_cfg == FAM_LEGENDRE) ? 64'sd0 : dy1;
            end else begin
                if (fam_cfg == FAM_LEGENDRE) begin
                    nv = i_div(s_sub(i_mul(f_mul(xq, yl), 2 * k + 1), i_mul(ylm1, k)), k + 1);
                    nd = 0;
                end else if (fam_cfg <= FAM_CHEB2) begin
                    nv = s_sub(i_mul(f_mul(xq, yl), 2), ylm1);
                    nd = s_sub(i_mul(s_add(yl, f_mul(xq, dyl)), 2), dylm1);
                end else if (fam_cfg == FAM_LAGUERRE) begin
                    w  = s_sub(i_mul(one, 2 * k + 1), xq);
                    nv = i_div(s_sub(f_mul(w, yl), i_mul(ylm1, k)), k + 1);
                    nd = i_div(s_sub(s_sub(f_mul(w, dyl), yl), i_mul(dylm1, k)), k + 1);
                end else begin
                    nv = s_sub(i_mul(f_mul(xq, yl), 2), i_mul(ylm1, 2 * k));
                    nd = i_mul(yl, 2 * (k + 1));
                end
                ylm1 = yl; yl = nv; dylm1 = dyl; dyl = nd;
            end
        end
        if (fam_cfg == FAM_LEGENDRE) begin
            if (l == 0) dv = 0;
            else if (l == 1) dv = one;
            else if (xr == xone || xr == -xone) begin
                dv = i_mul(one, l * (l + 1) / 2);
                // sign flips only at the left endpoint for even degree
                if (xr == -xone && l % 2 == 0) dv = -dv;
            end else begin
                mx = mag(xr);
                d = $signed(mx * mx - (64'd1 << (2 * XF)));
                dv = i_mul(f_div(s_sub(f_mul(xq, yl), ylm1), d), l);
            end
        end else dv = dyl;
        res = '{yl, dv, dom, sat_flag};
        return res;
    endfunction

    // ---------------- request driver ----------------
    initial begin
        in_ch.valid = 1'b0; in_ch.x_value = '0; in_ch.degree = '0;
        out_ch.ready = 1'b0;
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_ch.valid || in_fire) begin
                // after an accept (or while idle) decide on the next offer
                if (in_fire) void'(pending_reqs.pop_front());
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.x_value <= pending_reqs[0].x;
                    in_ch.degree <= pending_reqs[0].deg;
                end else in_ch.valid <= 1'b0;
            end
            out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------- result monitor ----------------
    always @(posedge clk) begin
        ope_result_t exp_r;
        if (rst_n) begin
            cycles <= cycles + 1;
            in_fire <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(eval_poly(in_ch.x_value, in_ch.degree));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (out_ch.poly_value !== exp_r.value) begin
                        $error("poly_value exp %h got %h", exp_r.value, out_ch.poly_value);
                        errors++;
                    end
                    if (out_ch.poly_derivative !== exp_r.slope) begin
                        $error("poly_derivative exp %h got %h", exp_r.slope,
                               out_ch.poly_derivative); errors++;
                    end
                    if (out_ch.domain_error !== exp_r.dom) begin
                        $error("domain_error exp %b got %b", exp_r.dom, out_ch.domain_error);
                        errors++;
                    end
                    if (out_ch.overflow !== exp_r.ovf) begin
                        $error("overflow exp %b got %b", exp_r.ovf, out_ch.overflow);
                        errors++;
                    end
                end
            end
            if (cycles > LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ---------------- config writes and stimulus ----------------
    task automatic write_family(input logic [2:0] f);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {29'd0, f};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        fam_cfg = f;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_point();
        case ($urandom_range(7))
            0: return $urandom();
            1: return 32'h1000_0000;
            2: return 32'hF000_0000;
            3: return $urandom_range(32'h2000_0000);
            default: return $signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000;
        endcase
    endfunction

    task automatic add_req(input logic [31:0] x, input logic [5:0] dg);
        eval_req_t r;
        r.x = x; r.deg = dg;
        pending_reqs.push_back(r);
    endtask

    // degrees stay small mostly, the largest only now and then
    function automatic logic [5:0] rand_degree();
        int p;
        p = $urandom_range(19);
        if (p == 0) return 6'($urandom_range(33, 63));
        if (p < 3) return 6'($urandom_range(20, 32));
        return 6'($urandom_range(0, 8));
    endfunction

    initial begin
        logic [2:0] fam_order[7];
        fam_cfg = FAM_LEGENDRE;
        fam_order = '{FAM_LEGENDRE, FAM_CHEB1, FAM_CHEB2, FAM_LAGUERRE, FAM_HERMITE,
                      3'd7, 3'd5};
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed: extremes of point and degree, endpoints, zero
        foreach (fam_order[i]) begin
            write_family(fam_order[i]);
            add_req(32'h1000_0000, 6'd5); add_req(32'hF000_0000, 6'd4);
            add_req(32'hF000_0000, 6'd3); add_req(32'h0, 6'd0);
            if (i < 2) begin
                add_req(32'h7FFF_FFFF, 6'd63); add_req(32'h8000_0000, 6'd32);
                add_req(32'h0800_0000, 6'd1); add_req(32'hAAAA_5555, 6'd2);
            end
            drain();
        end

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct  = (ph % 4 == 1) ? 62 : (ph % 4 == 3) ? 9 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 62 : (ph % 4 == 3) ? 9 : 0;
            write_family(ph < 5 ? fam_order[ph] : fam_order[$urandom_range(4)]);
            for (int n = 0; n < 55; n++) add_req(rand_point(), rand_degree());
            if (ph == 2) begin
                // long receiver hold while requests keep coming
                hold_recv = 1'b1;
                repeat (3000) @(posedge clk);
                hold_recv = 1'b0;
            end
            drain();
        end
        write_family(3'd6);
        add_req(32'($urandom()), 6'($urandom_range(63)));
        drain();
        write_family(FAM_LEGENDRE);
        for (int n = 0; n < 50; n++) add_req(rand_point(), rand_degree());
        drain();

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
